[sv/ale_pkg.sv]
// ----------------------------------------------------------------------------
// ale_pkg: shared definitions for the array list engine
// Sizes of the list storage, field widths and the operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ale_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 6;

    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_READ   = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FIND  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

[sv/array_list_engine.sv]
// ----------------------------------------------------------------------------
// array_list_engine: ordered list of signed words in a fixed array
// Find, read, insert and delete on a list held in a single-port-write RAM.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                                  Beat
//  input     in         s_valid/s_ready, s_opcode, s_value,    one operation
//                       s_position
//  result    out        m_valid/m_ready, m_status,             one result
//                       m_result_value, m_length
//
//  Find reads one entry per cycle through the registered read port; insert and
//  delete move one entry per cycle. A read fetches its entry in the read state;
//  a refused read, insert or delete goes straight to the response state.
//  Synchronous active-low reset empties the list; no clearing pass is needed.
//  A finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine
    import ale_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_opcode,
    input  wire logic signed [DATA_W-1:0] s_value,
    input  wire logic [POS_W-1:0]         s_position,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_status,
    output logic signed [DATA_W-1:0]      m_result_value,
    output logic [LEN_W-1:0]              m_length
);

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    op_t               op_reg, op_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [ADDR_W-1:0] chk_idx_reg, chk_idx_next;
    logic              res_status_reg, res_status_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_status_reg, m_status_next;
    logic [DATA_W-1:0] m_value_reg, m_value_next;
    logic [LEN_W-1:0]  m_length_reg, m_length_next;

    logic              accept;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [CNT_W:0]    pos_ext;
    logic [CNT_W:0]    cnt_ext;

    assign s_ready        = (state_reg == ST_IDLE);
    assign accept         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_value = m_value_reg;
    assign m_length       = m_length_reg;

    assign pos_ext = (CNT_W + 1)'(s_position);
    assign cnt_ext = (CNT_W + 1)'(count_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        m_length_next   = m_length_reg;
        rd_addr         = idx_reg[ADDR_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                rd_addr = ADDR_W'(s_position - 1'b1);
                if (accept) begin
                    op_next         = op_t'(s_opcode);
                    value_next      = s_value;
                    pos_next        = s_position;
                    chk_valid_next  = 1'b0;
                    res_status_next = 1'b1;
                    res_value_next  = '0;
                    state_next      = ST_RESP;
                    case (op_t'(s_opcode))
                        OP_FIND: begin
                            idx_next   = '0;
                            state_next = ST_FIND;
                        end
                        OP_READ: begin
                            if (s_position != '0 && pos_ext <= cnt_ext) begin
                                state_next = ST_READ;
                            end
                        end
                        OP_INSERT: begin
                            if (count_reg != CNT_W'(CAPACITY) && s_position != '0
                                    && pos_ext <= cnt_ext + 1'b1) begin
                                idx_next   = count_reg - 1'b1;
                                rem_next   = CNT_W'(cnt_ext - pos_ext + 1'b1);
                                state_next = ST_SHIFT;
                            end
                        end
                        OP_DELETE: begin
                            if (s_position != '0 && pos_ext <= cnt_ext) begin
                                idx_next   = CNT_W'(s_position);
                                rem_next   = CNT_W'(cnt_ext - pos_ext);
                                state_next = ST_SHIFT;
                            end
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_FIND: begin
                if (chk_valid_reg && rd_data_reg == value_reg) begin
                    res_status_next = 1'b0;
                    res_value_next  = DATA_W'(chk_idx_reg);
                    chk_valid_next  = 1'b0;
                    state_next      = ST_RESP;
                end else if (idx_reg < count_reg) begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = idx_reg[ADDR_W-1:0];
                    idx_next       = idx_reg + 1'b1;
                end else begin
                    chk_valid_next = 1'b0;
                    state_next     = ST_RESP;
                end
            end
            ST_READ: begin
                res_status_next = 1'b0;
                res_value_next  = rd_data_reg;
                state_next      = ST_RESP;
            end
            ST_SHIFT: begin
                if (chk_valid_reg) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg;
                    if (op_reg == OP_INSERT) begin
                        wr_addr = chk_idx_reg + 1'b1;
                    end else begin
                        wr_addr = chk_idx_reg - 1'b1;
                    end
                end
                if (rem_reg != '0) begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = idx_reg[ADDR_W-1:0];
                    rem_next       = rem_reg - 1'b1;
                    if (op_reg == OP_INSERT) begin
                        idx_next = idx_reg - 1'b1;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg) begin
                        res_status_next = 1'b0;
                        res_value_next  = '0;
                        state_next      = ST_RESP;
                        if (op_reg == OP_INSERT) begin
                            wr_en      = 1'b1;
                            wr_addr    = ADDR_W'(pos_reg - 1'b1);
                            wr_data    = value_reg;
                            count_next = count_reg + 1'b1;
                        end else begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    m_length_next = LEN_W'(count_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        op_reg         <= op_next;
        value_reg      <= value_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        rem_reg        <= rem_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_length_reg   <= m_length_next;
    end

endmodule

`default_nettype wire

[sv/ale_checker.sv]
// ----------------------------------------------------------------------------
// ale_checker: port-level checks for the array list engine
// Watches the top-level ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_checker
    import ale_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic                     m_status,
    input wire logic signed [DATA_W-1:0] m_result_value,
    input wire logic [LEN_W-1:0]         m_length
);

    // The engine works on one operation at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after a beat");

    // An error result carries a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_result_value == '0)
        else $error("error result with nonzero value");

    // The reported length never exceeds the list capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_length <= LEN_W'(CAPACITY))
        else $error("length beyond capacity");

    // A stalled result beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_result_value) && $stable(m_length))
        else $error("stalled result changed");

endmodule

bind array_list_engine ale_checker u_ale_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_result_value (m_result_value),
    .m_length       (m_length)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the array list engine
// Drives find, read, insert and delete operations through the input channel,
// predicts every result from a queue that mirrors the list, and compares each
// result beat field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ale_pkg::*;

    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] value;
        logic [LEN_W-1:0]         length;
    } list_result_t;

    class list_scoreboard;
        logic signed [DATA_W-1:0] contents[$];
        list_result_t             awaited[$];
        int failures;
        int checked;
        int rejected;
        int full_refusals;
        int longest;

        function void note_input(op_t op, logic signed [DATA_W-1:0] value,
                                 logic [POS_W-1:0] position);
            list_result_t r;
            int n;
            int p;
            int hit;
            n = contents.size();
            p = int'(position);
            r.status = 1'b1;
            r.value  = '0;
            case (op)
                OP_FIND: begin
                    hit = -1;
                    for (int i = 0; i < n; i++) begin
                        if (hit < 0 && contents[i] == value) hit = i;
                    end
                    if (hit >= 0) begin
                        r.status = 1'b0;
                        r.value  = hit;
                    end
                end
                OP_READ: begin
                    if (p >= 1 && p <= n) begin
                        r.status = 1'b0;
                        r.value  = contents[p-1];
                    end
                end
                OP_INSERT: begin
                    if (n >= CAPACITY) begin
                        full_refusals++;
                    end else if (p >= 1 && p <= n + 1) begin
                        contents.insert(p - 1, value);
                        r.status = 1'b0;
                    end
                end
                OP_DELETE: begin
                    if (p >= 1 && p <= n) begin
                        contents.delete(p - 1);
                        r.status = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            r.length = LEN_W'(contents.size());
            if (r.status) rejected++;
            if (contents.size() > longest) longest = contents.size();
            awaited.push_back(r);
        endfunction

        function void check_result(logic status, logic signed [DATA_W-1:0] value,
                                   logic [LEN_W-1:0] length);
            list_result_t e;
            if (awaited.size() == 0) begin
                $display({"%0t: unexpected result beat: expected none, ",
                          "got status %0d value %0d length %0d"},
                         $time, status, value, length);
                failures++;
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (status !== e.status) begin
                $display("%0t: status mismatch: expected %0d, got %0d",
                         $time, e.status, status);
                failures++;
            end
            if (value !== e.value) begin
                $display("%0t: result_value mismatch: expected %0d, got %0d",
                         $time, e.value, value);
                failures++;
            end
            if (length !== e.length) begin
                $display("%0t: length mismatch: expected %0d, got %0d",
                         $time, e.length, length);
                failures++;
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_opcode;
    logic signed [DATA_W-1:0] s_value;
    logic [POS_W-1:0]         s_position;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_status;
    logic signed [DATA_W-1:0] m_result_value;
    logic [LEN_W-1:0]         m_length;

    list_scoreboard sb = new();
    bit sender_quiet   = 1'b0;
    bit receiver_quiet = 1'b0;

    array_list_engine u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_value        (s_value),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_value (m_result_value),
        .m_length       (m_length)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_500_000;
        $display("array_list_engine verification failed");
        $finish;
    end

    task automatic send_op(op_t op, logic signed [DATA_W-1:0] value,
                           logic [POS_W-1:0] position);
        int gap;
        if ($urandom_range(0, 49) == 0) sender_quiet = !sender_quiet;
        gap = sender_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_value    <= value;
        s_position <= position;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_input(op, value, position);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_status, m_result_value, m_length);
        end
    end

    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if ($urandom_range(0, 49) == 0) receiver_quiet = !receiver_quiet;
            gap = receiver_quiet ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin
        op_t                      op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
        int                       n;
        int                       pick;
        bit                       grow;

        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_opcode   <= OP_FIND;
        s_value    <= '0;
        s_position <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Rejections on an empty list, then a short list built at head, middle and tail.
        send_op(OP_FIND,   0,        1);
        send_op(OP_READ,   0,        1);
        send_op(OP_DELETE, 0,        1);
        send_op(OP_INSERT, 7,        0);
        send_op(OP_INSERT, 7,        2);
        send_op(OP_INSERT, WORD_MIN, 1);
        send_op(OP_INSERT, WORD_MAX, 2);
        send_op(OP_INSERT, -1,       1);
        send_op(OP_INSERT, 5,        2);
        send_op(OP_INSERT, 5,        5);
        send_op(OP_FIND,   5,        0);
        send_op(OP_FIND,   WORD_MAX, 63);
        send_op(OP_FIND,   0,        0);
        send_op(OP_READ,   0,        0);
        send_op(OP_READ,   0,        5);
        send_op(OP_READ,   0,        6);
        send_op(OP_READ,   0,        63);
        send_op(OP_DELETE, 0,        6);
        send_op(OP_DELETE, 0,        0);
        send_op(OP_DELETE, 0,        1);
        send_op(OP_DELETE, 0,        4);
        send_op(OP_DELETE, 0,        2);
        send_op(OP_READ,   0,        1);
        send_op(OP_INSERT, 9,        63);
        send_op(OP_FIND,   WORD_MIN, 0);

        grow = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            n = sb.contents.size();
            if (n == CAPACITY) grow = 1'b0;
            if (n == 0) grow = 1'b1;
            if ($urandom_range(0, 79) == 0) grow = !grow;

            pick = $urandom_range(0, 99);
            if (grow) begin
                op = pick < 55 ? OP_INSERT : pick < 65 ? OP_DELETE :
                     pick < 85 ? OP_FIND : OP_READ;
            end else begin
                op = pick < 10 ? OP_INSERT : pick < 55 ? OP_DELETE :
                     pick < 80 ? OP_FIND : OP_READ;
            end

            pick = $urandom_range(0, 9);
            if (pick < 3) value = $urandom_range(0, 7);
            else if (pick == 3) value = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
            else value = $urandom;
            if (op == OP_FIND && n > 0 && $urandom_range(0, 2) != 0) begin
                value = sb.contents[$urandom_range(0, n - 1)];
            end

            if ($urandom_range(0, 6) == 0 || op == OP_FIND) begin
                position = POS_W'($urandom_range(0, 63));
            end else if (op == OP_INSERT) begin
                position = POS_W'($urandom_range(1, n + 1));
            end else if (n > 0) begin
                position = POS_W'($urandom_range(1, n));
            end else begin
                position = POS_W'($urandom_range(0, 63));
            end

            send_op(op, value, position);
        end
        s_valid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("Checked %0d result beats: %0d rejected operations, %0d inserts %s",
                 sb.checked, sb.rejected, sb.full_refusals, "refused on a full list.");
        $display("The list reached %0d of %0d entries.", sb.longest, CAPACITY);
        if (sb.failures == 0 && sb.awaited.size() == 0) begin
            $display("array_list_engine verification clean");
        end else begin
            $display("array_list_engine verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
sv/ale_pkg.sv
sv/array_list_engine.sv
sv/ale_checker.sv
tb/sv/tb_top.sv
